>>> hw/rtl/prcd_pkg.sv
// prcd_pkg: shared constants and register index codes for the peak/RMS
// column decimator. No dependencies.
package prcd_pkg;

  localparam int CFG_DATA_BITS = 21;
  localparam int COLUMN_BITS   = 12;
  localparam int HEIGHT_BITS   = 16;
  localparam int MAG_BITS      = 16;
  localparam int RAD_BITS      = 34;
  localparam int ROOT_BITS     = 17;
  localparam int LOG_FRAC_BITS = 16;
  localparam int DB_BITS       = 9;

  localparam logic [18:0] DB_PER_OCTAVE_Q16 = 19'd394566;
  localparam logic [15:0] HEIGHT_MAX        = 16'hFFFF;
  localparam logic [8:0]  DB_FLOOR_RESET    = 9'h1C4;

  typedef enum logic [1:0] {
    CFG_WAVE_LENGTH   = 2'd0,
    CFG_DISPLAY_WIDTH = 2'd1,
    CFG_LOG_MODE      = 2'd2,
    CFG_DB_FLOOR      = 2'd3
  } cfg_idx_t;

endpackage

>>> hw/rtl/prcd_div.sv
// prcd_div: restoring serial divider, one quotient bit per cycle.
// Standalone; used by the front and back units.
module prcd_div #(
  parameter int NW = 21,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   quo_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            ge;

  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

>>> hw/rtl/prcd_fifo.sv
// prcd_fifo: two-entry queue between column accumulation and column math.
// Standalone.
module prcd_fifo #(
  parameter int DW = 80
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          full,
  output logic          empty
);

  logic [DW-1:0] mem_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  assign dout  = mem_r[rp_r];
  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;

endmodule

>>> hw/rtl/prcd_front.sv
// prcd_front: takes samples, tracks column boundaries, accumulates peak and
// sum of squares, queues closed columns. Depends on prcd_pkg, prcd_div.
module prcd_front #(
  parameter int SB  = 16,
  parameter int LB  = 21,
  parameter int WB  = 13,
  parameter int CB  = 12,
  parameter int SSB = 51
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            restart,
  input  logic [LB-1:0]                   eff_len,
  input  logic [WB-1:0]                   eff_wid,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SB-1:0]            in_sample,
  input  logic                            fifo_full,
  output logic                            push,
  output logic [CB-1:0]                   p_col,
  output logic [SSB-1:0]                  p_sum,
  output logic [prcd_pkg::MAG_BITS-1:0]   p_peak,
  output logic                            p_last
);

  typedef enum logic [2:0] {
    F_START = 3'b001,
    F_DIV   = 3'b010,
    F_RUN   = 3'b100
  } f_state_t;

  localparam int MB = prcd_pkg::MAG_BITS;

  f_state_t       state_r, state_nxt;
  logic [LB-1:0]  cnt_r, cnt_nxt;
  logic [CB-1:0]  col_r, col_nxt;
  logic [LB-1:0]  bq_r, bq_nxt;
  logic [WB-1:0]  br_r, br_nxt;
  logic [LB-1:0]  lq_r, lq_nxt;
  logic [WB-1:0]  lr_r, lr_nxt;
  logic [SSB-1:0] sum_r, sum_nxt;
  logic [MB-1:0]  peak_r, peak_nxt;

  logic           div_done;
  logic [LB-1:0]  div_quot;
  logic [WB-1:0]  div_rem;

  logic [SB-1:0]    mag_raw;
  logic [SB+15:0]   mag_sh;
  logic [MB-1:0]    mag;
  logic [2*MB-1:0]  sq;
  logic [SSB-1:0]   sum_acc;
  logic [MB-1:0]    peak_acc;
  logic [LB-1:0]    cnt_inc;
  logic [CB:0]      col_inc;
  logic [WB:0]      r2;
  logic             close;
  logic             last;
  logic             accept;

  prcd_div #(.NW(LB), .DW(WB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == F_START),
    .num   (eff_len),
    .den   (eff_wid),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  assign mag_raw  = in_sample[SB-1] ? (~in_sample + 1'b1) : in_sample;
  assign mag_sh   = {mag_raw, 16'b0} >> SB;
  assign mag      = MB'(mag_sh);
  assign sq       = mag * mag;
  assign sum_acc  = sum_r + SSB'(sq);
  assign peak_acc = (mag > peak_r) ? mag : peak_r;
  assign cnt_inc  = cnt_r + 1'b1;
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign close    = cnt_inc >= bq_r;
  assign last     = col_inc >= (CB+1)'(eff_wid);
  assign r2       = {1'b0, br_r} + {1'b0, lr_r};

  assign in_ready = (state_r == F_RUN) && !fifo_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && close;
  assign p_col    = col_r;
  assign p_sum    = sum_acc;
  assign p_peak   = peak_acc;
  assign p_last   = last;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    bq_nxt    = bq_r;
    br_nxt    = br_r;
    lq_nxt    = lq_r;
    lr_nxt    = lr_r;
    sum_nxt   = sum_r;
    peak_nxt  = peak_r;
    if (restart) begin
      state_nxt = F_START;
      cnt_nxt   = '0;
      col_nxt   = '0;
      sum_nxt   = '0;
      peak_nxt  = '0;
    end else begin
      unique case (state_r)
        F_START: state_nxt = F_DIV;
        F_DIV: begin
          if (div_done) begin
            state_nxt = F_RUN;
            lq_nxt    = div_quot;
            lr_nxt    = div_rem;
            bq_nxt    = div_quot;
            br_nxt    = div_rem;
          end
        end
        F_RUN: begin
          if (accept) begin
            if (!close) begin
              cnt_nxt  = cnt_inc;
              sum_nxt  = sum_acc;
              peak_nxt = peak_acc;
            end else begin
              sum_nxt  = '0;
              peak_nxt = '0;
              if (last) begin
                cnt_nxt = '0;
                col_nxt = '0;
                bq_nxt  = lq_r;
                br_nxt  = lr_r;
              end else begin
                cnt_nxt = cnt_inc;
                col_nxt = CB'(col_inc);
                if (r2 >= {1'b0, eff_wid}) begin
                  bq_nxt = bq_r + lq_r + 1'b1;
                  br_nxt = WB'(r2 - {1'b0, eff_wid});
                end else begin
                  bq_nxt = bq_r + lq_r;
                  br_nxt = WB'(r2);
                end
              end
            end
          end
        end
        default: state_nxt = F_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_START;
      cnt_r   <= '0;
      col_r   <= '0;
      sum_r   <= '0;
      peak_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      sum_r   <= sum_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bq_r <= bq_nxt;
    br_r <= br_nxt;
    lq_r <= lq_nxt;
    lr_r <= lr_nxt;
  end

endmodule

>>> hw/rtl/prcd_back.sv
// prcd_back: per-column math: mean square, square root, linear or dB height,
// output register. Depends on prcd_pkg, prcd_div.
module prcd_back #(
  parameter int LB  = 21,
  parameter int WB  = 13,
  parameter int CB  = 12,
  parameter int SSB = 51
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [LB-1:0]                        eff_len,
  input  logic [WB-1:0]                        eff_wid,
  input  logic                                 log_mode,
  input  logic [prcd_pkg::DB_BITS-1:0]         db_floor,
  input  logic                                 fifo_empty,
  output logic                                 fifo_pop,
  input  logic [CB-1:0]                        f_col,
  input  logic [SSB-1:0]                       f_sum,
  input  logic [prcd_pkg::MAG_BITS-1:0]        f_peak,
  input  logic                                 f_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [prcd_pkg::COLUMN_BITS-1:0]     out_column,
  output logic [prcd_pkg::HEIGHT_BITS-1:0]     out_peak_height,
  output logic [prcd_pkg::HEIGHT_BITS-1:0]     out_rms_height,
  output logic                                 out_last_column
);

  typedef enum logic [11:0] {
    B_IDLE   = 12'b000000000001,
    B_MUL    = 12'b000000000010,
    B_QSTART = 12'b000000000100,
    B_QWAIT  = 12'b000000001000,
    B_SQRT   = 12'b000000010000,
    B_HGT    = 12'b000000100000,
    B_LOG    = 12'b000001000000,
    B_AMUL   = 12'b000010000000,
    B_ACHK   = 12'b000100000000,
    B_AWAIT  = 12'b001000000000,
    B_OUT    = 12'b010000000000,
    B_SPARE  = 12'b100000000000
  } b_state_t;

  localparam int MB  = prcd_pkg::MAG_BITS;
  localparam int HB  = prcd_pkg::HEIGHT_BITS;
  localparam int RB  = prcd_pkg::RAD_BITS;
  localparam int QB  = prcd_pkg::ROOT_BITS;
  localparam int FB  = prcd_pkg::LOG_FRAC_BITS;
  localparam int DBB = prcd_pkg::DB_BITS;
  localparam int PW  = SSB + WB;
  localparam int NW  = PW + 2;
  localparam int DW  = (LB > DBB + 16) ? LB : DBB + 16;

  b_state_t       state_r, state_nxt;
  logic [CB-1:0]  ecol_r;
  logic [SSB-1:0] esum_r;
  logic [MB-1:0]  epeak_r;
  logic           elast_r;
  logic [PW-1:0]  prod_r;
  logic [RB-1:0]  rad_r, rad_nxt;
  logic [QB-1:0]  root_r, root_nxt;
  logic [QB+1:0]  srem_r, srem_nxt;
  logic [4:0]     scnt_r, scnt_nxt;
  logic [QB-1:0]  m_r, m_nxt;
  logic           hsel_r, hsel_nxt;
  logic [30:0]    x_r, x_nxt;
  logic [3:0]     e_r, e_nxt;
  logic [FB-1:0]  frac_r, frac_nxt;
  logic [4:0]     lcnt_r, lcnt_nxt;
  logic [39:0]    a_r;
  logic [HB-1:0]  peak_h_r, peak_h_nxt;
  logic [HB-1:0]  rms_h_r, rms_h_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           load_out;

  logic           div_start;
  logic [NW-1:0]  div_num;
  logic [DW-1:0]  div_den;
  logic           div_done;
  logic [NW-1:0]  div_quot;

  logic [QB+3:0]  srem_sh;
  logic [QB+1:0]  trial;
  logic           sq_ge;
  logic [61:0]    xx;
  logic [31:0]    x2;
  logic [3:0]     e_find;
  logic [20:0]    n_val;
  logic [DBB-1:0] fm;
  logic           a_sat;
  logic [HB-1:0]  h_val;
  logic           h_commit;

  prcd_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   ()
  );

  assign fm      = db_floor[DBB-1] ? DBB'(~db_floor + 1'b1) : DBB'(1);
  assign a_sat   = {1'b0, a_r} >= {fm, 32'b0};
  assign n_val   = 21'(1 << 20) - 21'({e_r, frac_r});

  assign div_start = (state_r == B_QSTART) || ((state_r == B_ACHK) && !a_sat);
  assign div_num   = (state_r == B_QSTART) ? {prod_r, 2'b00} : NW'(a_r);
  assign div_den   = (state_r == B_QSTART) ? DW'(eff_len) : DW'({fm, 16'b0});

  assign srem_sh = {srem_r, rad_r[RB-1:RB-2]};
  assign trial   = {root_r, 2'b01};
  assign sq_ge   = srem_sh >= (QB+4)'(trial);

  assign xx = x_r * x_r;
  assign x2 = xx[61:30];

  always_comb begin
    e_find = '0;
    for (int i = 0; i < MB; i++) begin
      if (m_r[i]) e_find = 4'(i);
    end
  end

  assign fifo_pop = (state_r == B_IDLE) && !fifo_empty;
  assign load_out = (state_r == B_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    rad_nxt    = rad_r;
    root_nxt   = root_r;
    srem_nxt   = srem_r;
    scnt_nxt   = scnt_r;
    m_nxt      = m_r;
    hsel_nxt   = hsel_r;
    x_nxt      = x_r;
    e_nxt      = e_r;
    frac_nxt   = frac_r;
    lcnt_nxt   = lcnt_r;
    peak_h_nxt = peak_h_r;
    rms_h_nxt  = rms_h_r;
    h_val      = '0;
    h_commit   = 1'b0;
    unique case (state_r)
      B_IDLE:   if (!fifo_empty) state_nxt = B_MUL;
      B_MUL:    state_nxt = B_QSTART;
      B_QSTART: state_nxt = B_QWAIT;
      B_QWAIT: begin
        if (div_done) begin
          rad_nxt   = div_quot[RB-1:0];
          root_nxt  = '0;
          srem_nxt  = '0;
          scnt_nxt  = 5'(QB);
          state_nxt = B_SQRT;
        end
      end
      B_SQRT: begin
        rad_nxt  = {rad_r[RB-3:0], 2'b00};
        root_nxt = {root_r[QB-2:0], sq_ge};
        srem_nxt = sq_ge ? (QB+2)'(srem_sh - (QB+4)'(trial)) : (QB+2)'(srem_sh);
        scnt_nxt = scnt_r - 1'b1;
        if (scnt_r == 5'd1) begin
          m_nxt     = {epeak_r, 1'b0};
          hsel_nxt  = 1'b0;
          state_nxt = B_HGT;
        end
      end
      B_HGT: begin
        if (!log_mode) begin
          h_commit = 1'b1;
          if (m_r[QB-1])        h_val = '0;
          else if (m_r == '0)   h_val = prcd_pkg::HEIGHT_MAX;
          else                  h_val = HB'(QB'(1 << 16) - m_r);
        end else if (m_r == '0) begin
          h_commit = 1'b1;
          h_val    = prcd_pkg::HEIGHT_MAX;
        end else if (m_r[QB-1]) begin
          h_commit = 1'b1;
          h_val    = '0;
        end else begin
          e_nxt     = e_find;
          x_nxt     = 31'(m_r[MB-1:0]) << (5'd30 - {1'b0, e_find});
          frac_nxt  = '0;
          lcnt_nxt  = 5'(FB);
          state_nxt = B_LOG;
        end
      end
      B_LOG: begin
        frac_nxt = {frac_r[FB-2:0], x2[31]};
        x_nxt    = x2[31] ? x2[31:1] : x2[30:0];
        lcnt_nxt = lcnt_r - 1'b1;
        if (lcnt_r == 5'd1) state_nxt = B_AMUL;
      end
      B_AMUL: state_nxt = B_ACHK;
      B_ACHK: begin
        if (a_sat) begin
          h_commit = 1'b1;
          h_val    = prcd_pkg::HEIGHT_MAX;
        end else begin
          state_nxt = B_AWAIT;
        end
      end
      B_AWAIT: begin
        if (div_done) begin
          h_commit = 1'b1;
          h_val    = div_quot[HB-1:0];
        end
      end
      B_OUT:   if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
    if (h_commit) begin
      if (!hsel_r) begin
        peak_h_nxt = h_val;
        m_nxt      = root_r;
        hsel_nxt   = 1'b1;
        state_nxt  = B_HGT;
      end else begin
        rms_h_nxt = h_val;
        state_nxt = B_OUT;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      ecol_r  <= f_col;
      esum_r  <= f_sum;
      epeak_r <= f_peak;
      elast_r <= f_last;
    end
    if (state_r == B_MUL) prod_r <= esum_r * eff_wid;
    if (state_r == B_AMUL) a_r <= 40'(n_val) * 40'(prcd_pkg::DB_PER_OCTAVE_Q16);
    rad_r    <= rad_nxt;
    root_r   <= root_nxt;
    srem_r   <= srem_nxt;
    scnt_r   <= scnt_nxt;
    m_r      <= m_nxt;
    hsel_r   <= hsel_nxt;
    x_r      <= x_nxt;
    e_r      <= e_nxt;
    frac_r   <= frac_nxt;
    lcnt_r   <= lcnt_nxt;
    peak_h_r <= peak_h_nxt;
    rms_h_r  <= rms_h_nxt;
    if (load_out) begin
      out_column      <= prcd_pkg::COLUMN_BITS'(ecol_r);
      out_peak_height <= peak_h_r;
      out_rms_height  <= rms_h_nxt;
      out_last_column <= elast_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/peak_rms_column_decimator.sv
// peak_rms_column_decimator: top level; config registers, front, queue, back.
// Depends on prcd_pkg, prcd_front, prcd_fifo, prcd_back, prcd_div.
// Throughput: one sample per cycle while the front is running and the two-entry column queue has room.
// Column math runs a serial divide and a serial square root in linear mode; in dB mode each height
// adds 16 log steps and, unless the dB value saturates, a serial divide; that sets the column rate.
// Reset (synchronous, active low) and every config write restart the waveform;
// the front then runs its boundary divide before accepting.
module peak_rms_column_decimator #(
  parameter int SAMPLE_BITS     = 16,
  parameter int MAX_LENGTH_BITS = 20,
  parameter int MAX_COLUMNS     = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [prcd_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [prcd_pkg::COLUMN_BITS-1:0]       out_column,
  output logic [prcd_pkg::HEIGHT_BITS-1:0]       out_peak_height,
  output logic [prcd_pkg::HEIGHT_BITS-1:0]       out_rms_height,
  output logic                                   out_last_column
);

  localparam int LB  = MAX_LENGTH_BITS + 1;
  localparam int CB  = $clog2(MAX_COLUMNS);
  localparam int WB  = CB + 1;
  localparam int SSB = MAX_LENGTH_BITS + 31;
  localparam int MB  = prcd_pkg::MAG_BITS;
  localparam int EW  = CB + SSB + MB + 1;
  localparam logic [31:0] LMAX = 32'(2 ** MAX_LENGTH_BITS);
  localparam logic [31:0] CMAX = 32'(MAX_COLUMNS);

  logic [20:0]                   wave_length_r;
  logic [12:0]                   display_width_r;
  logic                          log_mode_r;
  logic [prcd_pkg::DB_BITS-1:0]  db_floor_r;

  logic [31:0]    wl32, dw32, wlim, len32, wid32;
  logic [LB-1:0]  eff_len;
  logic [WB-1:0]  eff_wid;

  logic           push, pop, fifo_full, fifo_empty;
  logic [CB-1:0]  p_col;
  logic [SSB-1:0] p_sum;
  logic [MB-1:0]  p_peak;
  logic           p_last;
  logic [EW-1:0]  fifo_din, fifo_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_length_r   <= 21'd1;
      display_width_r <= 13'd1;
      log_mode_r      <= 1'b0;
      db_floor_r      <= prcd_pkg::DB_FLOOR_RESET;
    end else if (cfg_we) begin
      unique case (prcd_pkg::cfg_idx_t'(cfg_index))
        prcd_pkg::CFG_WAVE_LENGTH:   wave_length_r   <= cfg_wdata;
        prcd_pkg::CFG_DISPLAY_WIDTH: display_width_r <= 13'(cfg_wdata);
        prcd_pkg::CFG_LOG_MODE:      log_mode_r      <= cfg_wdata[0];
        prcd_pkg::CFG_DB_FLOOR:      db_floor_r      <= prcd_pkg::DB_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    wl32 = 32'(wave_length_r);
    dw32 = 32'(display_width_r);
    if (wl32 == '0)       len32 = 32'd1;
    else if (wl32 > LMAX) len32 = LMAX;
    else                  len32 = wl32;
    wlim = (CMAX < len32) ? CMAX : len32;
    if (dw32 == '0)       wid32 = 32'd1;
    else if (dw32 > wlim) wid32 = wlim;
    else                  wid32 = dw32;
  end

  assign eff_len = LB'(len32);
  assign eff_wid = WB'(wid32);

  prcd_front #(.SB(SAMPLE_BITS), .LB(LB), .WB(WB), .CB(CB), .SSB(SSB)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_we),
    .eff_len   (eff_len),
    .eff_wid   (eff_wid),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .fifo_full (fifo_full),
    .push      (push),
    .p_col     (p_col),
    .p_sum     (p_sum),
    .p_peak    (p_peak),
    .p_last    (p_last)
  );

  assign fifo_din = {p_col, p_sum, p_peak, p_last};

  prcd_fifo #(.DW(EW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (fifo_din),
    .pop   (pop),
    .dout  (fifo_dout),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  prcd_back #(.LB(LB), .WB(WB), .CB(CB), .SSB(SSB)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .eff_len         (eff_len),
    .eff_wid         (eff_wid),
    .log_mode        (log_mode_r),
    .db_floor        (db_floor_r),
    .fifo_empty      (fifo_empty),
    .fifo_pop        (pop),
    .f_col           (fifo_dout[EW-1 -: CB]),
    .f_sum           (fifo_dout[MB+SSB : MB+1]),
    .f_peak          (fifo_dout[MB:1]),
    .f_last          (fifo_dout[0]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column      (out_column),
    .out_peak_height (out_peak_height),
    .out_rms_height  (out_rms_height),
    .out_last_column (out_last_column)
  );

`ifndef SYNTHESIS
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted right after config write");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && fifo_full))
    else $error("column queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && fifo_empty))
    else $error("column queue underflow");
`endif

endmodule
